// ----- rtl/orb_pkg.sv -----
// Shared types and constants for the offset reorder ring buffer.
// No dependencies; the top level, orb_ptr_ctrl and orb_valid_map import this package.
`default_nettype none

package orb_pkg;

    // Fixed field widths of the item and result channels
    localparam int CMD_W     = 1;
    localparam int OFFSET_W  = 32;
    localparam int PAYLOAD_W = 32;
    localparam int DATA_W    = 32;
    localparam int OCC_W     = 9;
    localparam int CAP_W     = 9;

    localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
    localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } orb_state_t;

    // Per-cycle operation on the slot memory and its valid map
    typedef struct packed {
        logic wr_en;    // write one slot
        logic rd_en;    // read the head slot
        logic clr_all;  // drop every valid mark
        logic clr_gap;  // drop valid marks of the skipped slots
    } slot_op_t;

endpackage

`default_nettype wire

// ----- rtl/offset_reorder_ring_buffer.sv -----
// Top level of the offset reorder ring buffer: handshakes, sequencer, result register.
// Depends on orb_pkg, orb_ptr_ctrl, orb_valid_map and orb_slot_mem.
`default_nettype none

// Reorder ring buffer of packet slots. A push (command 0) places its payload
// at slot_offset slots from the head: inside the filled span it overwrites in
// place, beyond it the skipped slots read back as zero and the word is appended;
// a jump of a whole capacity or more restarts the buffer at slot zero. When the
// count reaches capacity the head follows the tail. A pop (command 1) returns
// the head word; a pop of an empty buffer returns zero with m_was_empty set.
// Every item gives exactly one result carrying the occupancy after the item.
// Timing: an item is captured, then runs the read-modify-write on the slot
// memory in the execute state; the memory's read port is registered. The
// result enters the output register in the cycle after execute, which
// overlaps the capture of the next item, so with m_ready high the block takes
// a new item while the last result moves out, but none while one executes.
// Cleared slots are tracked by one valid flop per slot, so reset, a capacity
// write and a large jump clear the store at once with no sweep. Writing
// cfg_data sets the capacity (0 reads as 1, above MAX_SLOTS is clamped) and
// empties the buffer; cfg_ready is high whenever no item is executing.
module offset_reorder_ring_buffer #(
    parameter int MAX_SLOTS = 256,
    parameter int WORD_BITS = 32
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // item channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [orb_pkg::CMD_W-1:0]          s_command,
    input  wire logic [orb_pkg::OFFSET_W-1:0]       s_slot_offset,
    input  wire logic [orb_pkg::PAYLOAD_W-1:0]      s_payload,
    // result channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [orb_pkg::DATA_W-1:0]              m_data,
    output logic                                    m_was_empty,
    output logic [orb_pkg::OCC_W-1:0]               m_occupancy,
    // capacity register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [orb_pkg::CAP_W-1:0]          cfg_data
);

    import orb_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);

    orb_state_t state_reg, state_next;

    // captured item
    logic [CMD_W-1:0]     cmd_reg;
    logic [OFFSET_W-1:0]  off_reg;
    logic [PAYLOAD_W-1:0] pay_reg;

    // result waiting for the output register
    logic                 pend_reg;
    logic                 rsp_empty_reg;
    logic                 rsp_mem_reg;
    logic [CNT_W-1:0]     rsp_occ_reg;

    // output register
    logic                 m_valid_reg;
    logic [DATA_W-1:0]    m_data_reg;
    logic                 m_was_empty_reg;
    logic [OCC_W-1:0]     m_occupancy_reg;

    logic                 s_accept;
    logic                 exec;
    logic                 cfg_we;
    logic                 out_load;

    slot_op_t             op;
    logic [IDX_W-1:0]     wr_idx, rd_idx, gap_base;
    logic [CNT_W-1:0]     gap_len, cap, rsp_occ;
    logic                 rsp_empty;
    logic                 rd_valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    // The pending result moves out whenever the output register is free
    // or being drained this cycle.
    assign out_load  = pend_reg && (!m_valid_reg || m_ready);
    // A new item is taken only when its result will have a place to go.
    assign s_ready   = (state_reg == ST_IDLE) && (!pend_reg || out_load);
    assign s_accept  = s_valid && s_ready;
    assign exec      = (state_reg == ST_EXEC);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_we    = cfg_valid && cfg_ready;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg <= s_command;
            off_reg <= s_slot_offset;
            pay_reg <= s_payload;
        end
    end

    // ---------------------------------------------------------------
    // Pointer control, valid map and slot memory
    // ---------------------------------------------------------------
    orb_ptr_ctrl #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_cap   (cfg_data),
        .exec      (exec),
        .cmd       (cmd_reg),
        .offset    (off_reg),
        .op        (op),
        .wr_idx    (wr_idx),
        .rd_idx    (rd_idx),
        .gap_base  (gap_base),
        .gap_len   (gap_len),
        .cap       (cap),
        .rsp_empty (rsp_empty),
        .rsp_occ   (rsp_occ)
    );

    orb_valid_map #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_valid (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op           (op),
        .wr_idx       (wr_idx),
        .rd_idx       (rd_idx),
        .gap_base     (gap_base),
        .gap_len      (gap_len),
        .cap          (cap),
        .rd_valid_reg (rd_valid_reg)
    );

    orb_slot_mem #(
        .MAX_SLOTS (MAX_SLOTS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .aclk        (aclk),
        .wr_en       (op.wr_en),
        .wr_idx      (wr_idx),
        .wr_word     (WORD_BITS'(pay_reg)),
        .rd_en       (op.rd_en),
        .rd_idx      (rd_idx),
        .rd_word_reg (rd_word_reg)
    );

    // ---------------------------------------------------------------
    // Result staging: the memory read lands in the cycle after execute,
    // and stays put until the result moves to the output register.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (exec) begin
            pend_reg <= 1'b1;
        end else if (out_load) begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            rsp_empty_reg <= rsp_empty;
            rsp_mem_reg   <= op.rd_en;
            rsp_occ_reg   <= rsp_occ;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            // a slot without its valid mark holds zero
            m_data_reg      <= (rsp_mem_reg && rd_valid_reg) ? DATA_W'(rd_word_reg) : '0;
            m_was_empty_reg <= rsp_empty_reg;
            m_occupancy_reg <= OCC_W'(rsp_occ_reg);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;
    assign m_was_empty = m_was_empty_reg;
    assign m_occupancy = m_occupancy_reg;

`ifndef SYNTH
    a_result_staged: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> ##1 pend_reg)
        else $error("accepted item produced no staged result");

    a_empty_pop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_was_empty_reg) |-> (m_data_reg == '0))
        else $error("empty pop carries nonzero data");
`endif

endmodule

`default_nettype wire

// ----- rtl/orb_slot_mem.sv -----
// Slot word storage: one write port, one read port, registered read data.
// Depends on nothing outside this file.
`default_nettype none

module orb_slot_mem #(
    parameter int MAX_SLOTS = 256,
    parameter int WORD_BITS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(MAX_SLOTS)-1:0] wr_idx,
    input  wire logic [WORD_BITS-1:0]         wr_word,
    input  wire logic                         rd_en,
    input  wire logic [$clog2(MAX_SLOTS)-1:0] rd_idx,
    output logic      [WORD_BITS-1:0]         rd_word_reg
);

    logic [WORD_BITS-1:0] mem [MAX_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_word_reg <= mem[rd_idx];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/orb_valid_map.sv -----
// Per-slot valid marks: a slot without a mark reads as zero.
// Depends on orb_pkg for the slot operation struct.
`default_nettype none

module orb_valid_map #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire orb_pkg::slot_op_t                op,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]     wr_idx,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]     rd_idx,
    input  wire logic [$clog2(MAX_SLOTS)-1:0]     gap_base,
    input  wire logic [$clog2(MAX_SLOTS+1)-1:0]   gap_len,
    input  wire logic [$clog2(MAX_SLOTS+1)-1:0]   cap,
    output logic                                  rd_valid_reg
);

    import orb_pkg::*;

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int W1    = CNT_W + 1;

    logic [MAX_SLOTS-1:0] valid_reg;
    logic [MAX_SLOTS-1:0] valid_next;
    logic [MAX_SLOTS-1:0] in_gap;

    // Distance of each slot from the gap start, modulo capacity
    always_comb begin
        logic [W1-1:0] pos;
        logic [W1-1:0] rel;
        in_gap = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            pos = W1'(i);
            rel = (pos >= W1'(gap_base)) ? pos - W1'(gap_base)
                                         : pos + W1'(cap) - W1'(gap_base);
            in_gap[i] = (rel < W1'(gap_len));
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (op.clr_all) begin
            valid_next = '0;
        end else if (op.clr_gap) begin
            valid_next = valid_reg & ~in_gap;
        end
        if (op.wr_en) begin
            valid_next[wr_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (op.rd_en) begin
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/orb_ptr_ctrl.sv -----
// Head, tail, count and capacity registers with the push/pop decision logic.
// Depends on orb_pkg; drives the slot memory and valid map operations.
`default_nettype none

module orb_ptr_ctrl #(
    parameter int MAX_SLOTS = 256
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [orb_pkg::CAP_W-1:0]          cfg_cap,
    input  wire logic                               exec,
    input  wire logic [orb_pkg::CMD_W-1:0]          cmd,
    input  wire logic [orb_pkg::OFFSET_W-1:0]       offset,
    output orb_pkg::slot_op_t                       op,
    output logic [$clog2(MAX_SLOTS)-1:0]            wr_idx,
    output logic [$clog2(MAX_SLOTS)-1:0]            rd_idx,
    output logic [$clog2(MAX_SLOTS)-1:0]            gap_base,
    output logic [$clog2(MAX_SLOTS+1)-1:0]          gap_len,
    output logic [$clog2(MAX_SLOTS+1)-1:0]          cap,
    output logic                                    rsp_empty,
    output logic [$clog2(MAX_SLOTS+1)-1:0]          rsp_occ
);

    import orb_pkg::*;

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int W1    = CNT_W + 1;
    localparam int KW    = OFFSET_W + 1;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] cap_reg, cap_next;

    logic [W1-1:0] cap_w, head_w, tail_w, span_w;
    logic [W1-1:0] k_w1, inpl_w, last_w, tail_app_w, head_inc_w, total_w;
    logic [KW-1:0] k_w;
    logic          in_span;
    logic          big_jump;

    function automatic logic [W1-1:0] wrap1(input logic [W1-1:0] v,
                                            input logic [W1-1:0] c);
        return (v >= c) ? v - c : v;
    endfunction

    always_comb begin
        cap_w  = W1'(cap_reg);
        head_w = W1'(head_reg);
        tail_w = W1'(tail_reg);
        // filled span; reads zero when full
        span_w = (tail_w >= head_w) ? tail_w - head_w : tail_w + cap_w - head_w;
        in_span  = KW'(offset) < KW'(span_w);
        k_w      = KW'(offset) - KW'(span_w) + KW'(1);
        big_jump = k_w >= KW'(cap_w);
        k_w1     = k_w[W1-1:0];
        inpl_w     = wrap1(head_w + W1'(offset), cap_w);
        last_w     = wrap1(tail_w + k_w1 - W1'(1), cap_w);
        tail_app_w = wrap1(tail_w + k_w1, cap_w);
        head_inc_w = wrap1(head_w + W1'(1), cap_w);
        total_w    = W1'(count_reg) + k_w1;
    end

    always_comb begin
        op         = '0;
        wr_idx     = '0;
        rd_idx     = head_reg;
        gap_base   = tail_reg;
        gap_len    = k_w1[CNT_W-1:0];
        rsp_empty  = 1'b0;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;

        if (exec) begin
            if (cmd == CMD_PUSH) begin
                op.wr_en = 1'b1;
                if (in_span) begin
                    wr_idx = IDX_W'(inpl_w);
                end else if (big_jump) begin
                    // restart at slot zero, buffer full
                    op.clr_all = 1'b1;
                    wr_idx     = '0;
                    tail_next  = (cap_reg == CNT_W'(1)) ? '0 : IDX_W'(1);
                    count_next = cap_reg;
                    head_next  = tail_next;
                end else begin
                    op.clr_gap = 1'b1;
                    wr_idx     = IDX_W'(last_w);
                    tail_next  = IDX_W'(tail_app_w);
                    count_next = (total_w < cap_w) ? CNT_W'(total_w) : cap_reg;
                    if (count_next == cap_reg) begin
                        head_next = tail_next;
                    end
                end
            end else if (count_reg == '0) begin
                rsp_empty = 1'b1;
            end else begin
                op.rd_en   = 1'b1;
                head_next  = IDX_W'(head_inc_w);
                count_next = count_reg - CNT_W'(1);
            end
        end

        if (cfg_we) begin
            op.clr_all = 1'b1;
        end
    end

    always_comb begin
        if (cfg_cap == '0) begin
            cap_next = CNT_W'(1);
        end else if (32'(cfg_cap) > 32'(MAX_SLOTS)) begin
            cap_next = CNT_W'(MAX_SLOTS);
        end else begin
            cap_next = CNT_W'(cfg_cap);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= CNT_W'(MAX_SLOTS);
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else if (cfg_we) begin
            cap_reg   <= cap_next;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign cap     = cap_reg;
    assign rsp_occ = count_next;

`ifndef SYNTH
    a_count_le_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= cap_reg)
        else $error("slot count above capacity");

    a_ptrs_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (CNT_W'(head_reg) < cap_reg) && (CNT_W'(tail_reg) < cap_reg))
        else $error("head or tail outside capacity");

    a_empty_or_full_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0 || count_reg == cap_reg) |-> head_reg == tail_reg)
        else $error("head and tail disagree with count");
`endif

endmodule

`default_nettype wire

// ----- bench/orb_ring_checker.sv -----
// Scoreboard for the offset reorder ring buffer: tracks slot words, pointers and fill
// from the accepted items and capacity writes, and compares every result item.
// Depends on orb_pkg for the field widths and command codes.
module orb_ring_checker #(
    parameter int RING_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [orb_pkg::CMD_W-1:0]     s_command,
    input  logic [orb_pkg::OFFSET_W-1:0]  s_slot_offset,
    input  logic [orb_pkg::PAYLOAD_W-1:0] s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [orb_pkg::DATA_W-1:0]    m_data,
    input  logic                          m_was_empty,
    input  logic [orb_pkg::OCC_W-1:0]     m_occupancy,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [orb_pkg::CAP_W-1:0]     cfg_data,
    output int                            err_cnt,
    output int                            pend_cnt
);
    timeunit 1ns;
    timeprecision 1ps;
    import orb_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              was_empty;
        logic [OCC_W-1:0]  occupancy;
    } ring_result_t;

    logic [DATA_W-1:0] slot_words [RING_DEPTH];
    int unsigned       head_ix;
    int unsigned       tail_ix;
    int unsigned       fill;
    int unsigned       cap = RING_DEPTH;
    ring_result_t      due_q [$];
    int                errors = 0;

    task automatic wipe_words();
        foreach (slot_words[i]) slot_words[i] = '0;
    endtask

    task automatic ring_empty();
        wipe_words();
        head_ix = 0;
        tail_ix = 0;
        fill    = 0;
    endtask

    task automatic ring_set_capacity(input logic [CAP_W-1:0] v);
        int unsigned c;
        c = v;
        if (c < 1) c = 1;
        if (c > RING_DEPTH) c = RING_DEPTH;
        cap = c;
        ring_empty();
    endtask

    // Late word lands in place; anything past the span zero-fills and appends.
    task automatic ring_push(input logic [OFFSET_W-1:0] off, input logic [DATA_W-1:0] word);
        longint unsigned span, k, total, o, i;
        o    = off;
        span = (longint'(tail_ix) + cap - head_ix) % cap;
        if (o < span) begin
            slot_words[(head_ix + o) % cap] = word;
        end else begin
            k     = o - span + 1;
            total = fill + k;
            fill  = (total < cap) ? 32'(total) : cap;
            if (k >= cap) begin
                // jump of a whole ring: restart at slot zero
                wipe_words();
                head_ix       = 0;
                slot_words[0] = word;
                tail_ix       = 1 % cap;
            end else begin
                for (i = 0; i < k; i++) slot_words[(tail_ix + i) % cap] = '0;
                slot_words[(tail_ix + k - 1) % cap] = word;
                tail_ix = 32'((tail_ix + k) % cap);
            end
            if (fill == cap) head_ix = tail_ix;
        end
    endtask

    task automatic ring_item(input logic [CMD_W-1:0] cmd, input logic [OFFSET_W-1:0] off,
                             input logic [PAYLOAD_W-1:0] pay);
        ring_result_t r;
        r.data      = '0;
        r.was_empty = 1'b0;
        if (cmd == CMD_PUSH) begin
            ring_push(off, pay);
        end else if (fill == 0) begin
            r.was_empty = 1'b1;
        end else begin
            r.data  = slot_words[head_ix];
            head_ix = (head_ix + 1) % cap;
            fill    = fill - 1;
        end
        r.occupancy = fill[OCC_W-1:0];
        due_q.push_back(r);
    endtask

    task automatic report(input string what, input logic [DATA_W-1:0] want,
                          input logic [DATA_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endtask

    always @(posedge aclk) begin
        ring_result_t want;
        if (!aresetn) begin
            cap = RING_DEPTH;
            ring_empty();
            due_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) ring_set_capacity(cfg_data);
            if (m_valid && m_ready) begin
                if (due_q.size() == 0) begin
                    errors++;
                    $display("%0t: result item mismatch, expected none, actual data 0x%0h",
                             $time, m_data);
                end else begin
                    want = due_q.pop_front();
                    if (m_data !== want.data) report("data", want.data, m_data);
                    if (m_was_empty !== want.was_empty)
                        report("was_empty", want.was_empty, m_was_empty);
                    if (m_occupancy !== want.occupancy)
                        report("occupancy", want.occupancy, m_occupancy);
                end
            end
            if (s_valid && s_ready) ring_item(s_command, s_slot_offset, s_payload);
        end
        err_cnt  <= errors;
        pend_cnt <= due_q.size();
    end

endmodule

// ----- bench/tb_offset_reorder_ring_buffer.sv -----
// Top of the ring buffer bench: clock, reset, item and capacity stimulus, verdict.
// Depends on orb_pkg, the offset_reorder_ring_buffer RTL and orb_ring_checker.
module tb_offset_reorder_ring_buffer;
    timeunit 1ns;
    timeprecision 1ps;
    import orb_pkg::*;

    localparam int RING_DEPTH  = 256;
    localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 142;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_command     = CMD_PUSH;
    logic [OFFSET_W-1:0]  s_slot_offset = '0;
    logic [PAYLOAD_W-1:0] s_payload     = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [DATA_W-1:0]    m_data;
    logic                 m_was_empty;
    logic [OCC_W-1:0]     m_occupancy;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_data      = '0;

    int err_cnt;
    int pend_cnt;

    // idle rates in percent, changed per phase
    int send_idle_pct = 6;
    int recv_idle_pct = 54;

    // capacity the block is running with, for shaping offsets
    int unsigned cap_now = RING_DEPTH;

    int n_push      = 0;
    int n_pop       = 0;
    int n_cfg       = 0;
    int n_results   = 0;
    int idle_cycles = 0;

    offset_reorder_ring_buffer #(
        .MAX_SLOTS (RING_DEPTH),
        .WORD_BITS (32)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_slot_offset (s_slot_offset),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .m_was_empty   (m_was_empty),
        .m_occupancy   (m_occupancy),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Scoreboard sits beside the block on the same wires.
    orb_ring_checker #(
        .RING_DEPTH (RING_DEPTH)
    ) i_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_slot_offset (s_slot_offset),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .m_was_empty   (m_was_empty),
        .m_occupancy   (m_occupancy),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .err_cnt       (err_cnt),
        .pend_cnt      (pend_cnt)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure: redrawn every cycle, one assignment per edge.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if (m_valid && m_ready) n_results++;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // One item on the input channel. Random gaps before it; valid is only
    // dropped inside a gap, so back-to-back items keep it high.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [OFFSET_W-1:0] off,
                             input logic [PAYLOAD_W-1:0] pay);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_command     <= cmd;
        s_slot_offset <= off;
        s_payload     <= pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (cmd == CMD_PUSH) n_push++;
        else n_pop++;
    endtask

    // Hold the sender off until every outstanding result item has come back.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pend_cnt != 0) @(posedge aclk);
    endtask

    // Capacity write, only with the block idle. Every item yields a result,
    // so after the drain the block holds no item; spare idle cycles follow.
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        n_cfg++;
        if (v == 0) cap_now = 1;
        else if (v > RING_DEPTH) cap_now = RING_DEPTH;
        else cap_now = v;
    endtask

    function automatic logic [PAYLOAD_W-1:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        return $urandom();
    endfunction

    // Random item. Pops and short offsets dominate so the ring stays partly
    // filled and late writes land inside the span; longer jumps fill the
    // ring up or restart it, and full-width offsets exercise every bit.
    task automatic random_item();
        int unsigned sel;
        logic [OFFSET_W-1:0] off;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            send_item(CMD_POP, $urandom(), $urandom());
        end else begin
            sel = $urandom_range(0, 99);
            if (sel < 45) off = $urandom_range(0, 3);
            else if (sel < 70) off = $urandom_range(0, cap_now);
            else if (sel < 85) off = cap_now - 1 + $urandom_range(0, 2);
            else if (sel < 93) off = $urandom();
            else off = 32'hFFFF_FFFF - $urandom_range(0, 3);
            send_item(CMD_PUSH, off, pick_word());
        end
    endtask

    function automatic logic [CAP_W-1:0] phase_capacity(input int p);
        case (p)
            0: return 3;
            1: return 1;
            2: return 511;    // clamps to the full ring
            3: return 0;      // reads as one slot
            4: return 2;
            5: return 257;
            6: return CAP_W'($urandom_range(4, 64));
            default: return CAP_W'(RING_DEPTH);
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part on the reset capacity.
        send_item(CMD_POP,  0, 0);                        // pop of an empty ring
        send_item(CMD_PUSH, 0, 32'h0000_0000);
        send_item(CMD_PUSH, 0, 32'hFFFF_FFFF);            // overwrite in place
        send_item(CMD_PUSH, 4, 32'hA5A5_A5A5);            // gap gets zero-filled
        send_item(CMD_PUSH, 2, 32'h5A5A_5A5A);            // late word into the gap
        send_item(CMD_POP,  0, 0);
        send_item(CMD_POP,  0, 0);                        // zero from the filled gap
        send_item(CMD_PUSH, 255, 32'h0000_0001);          // fills the ring exactly
        send_item(CMD_PUSH, 0, 32'h0000_0002);            // full: head follows tail
        send_item(CMD_POP,  0, 0);
        send_item(CMD_PUSH, 300, 32'h0000_0003);          // jump past capacity
        send_item(CMD_POP,  0, 0);
        send_item(CMD_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // largest offset
        send_item(CMD_PUSH, 32'h8000_0000, 32'h8000_0001);
        send_item(CMD_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_POP,  0, 0);

        // Random phases, each on a fresh capacity.
        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 6;
                recv_idle_pct = 54;
            end else if (p < 6) begin
                send_idle_pct = 54;
                recv_idle_pct = 6;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_capacity(phase_capacity(p));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2) drain();   // sender waits for an empty pipe
                random_item();
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Ran %0d pushes and %0d pops over %0d capacity writes;", n_push, n_pop, n_cfg);
        $display("%0d result items compared, %0d mismatches.", n_results, err_cnt);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
